@@ rtl/acp_pkg.sv @@
// Package with shared types, codes and constants of the pheromone engine.
`default_nettype none
package acp_pkg;

    localparam int MAX_CELLS_DEF  = 1024;
    localparam int MAX_VALUES_DEF = 32;
    localparam int ACC_W          = 50;

    localparam logic [16:0] W_KEEP = 17'd58982;
    localparam logic [16:0] W_ADD  = 17'd6554;

    localparam logic [10:0] RST_CELL_COUNT  = 11'd81;
    localparam logic [31:0] RST_INIT_LEVEL  = 32'd809;
    localparam logic [15:0] RST_REINF_RATE  = 16'd6554;
    localparam logic [15:0] RST_BEST_DECAY  = 16'd655;

    typedef enum logic [2:0] {
        OP_CLEAR  = 3'd0,
        OP_READ   = 3'd1,
        OP_UPDATE = 3'd2,
        OP_LOAD   = 3'd3,
        OP_END    = 3'd4
    } t_opcode;

    typedef enum logic [1:0] {
        REG_CELL_COUNT = 2'd0,
        REG_INIT_LEVEL = 2'd1,
        REG_REINF_RATE = 2'd2,
        REG_BEST_DECAY = 2'd3
    } t_reg_idx;

    typedef enum logic [1:0] {
        MAC_IDLE,
        MAC_LOAD,
        MAC_ADD
    } t_mac_op;

    typedef enum logic [2:0] {
        MS_UPD_OLD,
        MS_UPD_INIT,
        MS_RF_OLD,
        MS_RF_BEST,
        MS_DECAY
    } t_mac_src;

    typedef enum logic [1:0] {
        TW_SWEEP,
        TW_ITEM,
        TW_RF
    } t_tbl_wsel;

    typedef struct packed {
        logic      cap;
        logic      cnt_clr;
        logic      cnt_inc;
        logic      fill_latch;
        logic      best_clr;
        logic      tbl_we;
        t_tbl_wsel tbl_wsel;
        logic      tbl_re;
        logic      tbl_rsel_rf;
        logic      best_sweep_we;
        logic      best_copy_we;
        logic      cand_we;
        logic      sol_re;
        logic      word_latch;
        t_mac_op   mac_op;
        t_mac_src  mac_src;
        logic      level_from_rd;
        logic      level_from_mac;
        logic      err_set;
        logic      div_start;
        logic      div_step;
        logic      div_finish;
        logic      commit;
        logic      decay_wr;
        logic      out_load;
    } t_cmd;

    typedef struct packed {
        logic [2:0] op;
        logic       range_err;
        logic       diff_zero;
        logic       div_done;
        logic       cnt_tbl_last;
        logic       cnt_cell_last;
        logic       rf_hit;
        logic       out_free;
    } t_stat;

endpackage
`default_nettype wire

@@ rtl/acp_if.sv @@
// Channel interfaces for requests, results and register writes.
`default_nettype none
interface acp_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  opcode;
    logic [9:0]  cell_req;
    logic [4:0]  choice;
    logic        cell_fixed;
    logic [10:0] filled_count;
    modport source(output valid, opcode, cell_req, choice, cell_fixed, filled_count,
                   input ready);
    modport sink(input valid, opcode, cell_req, choice, cell_fixed, filled_count,
                 output ready);
endinterface

interface acp_rsp_if;
    logic        valid;
    logic        ready;
    logic [31:0] level;
    logic [31:0] deposit;
    logic        improved;
    logic        solved;
    logic        range_error;
    modport source(output valid, level, deposit, improved, solved, range_error,
                   input ready);
    modport sink(input valid, level, deposit, improved, solved, range_error,
                 output ready);
endinterface

interface acp_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [31:0] data;
    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

@@ rtl/acp_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module acp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule
`default_nettype wire

@@ rtl/acp_datapath.sv @@
// Datapath: registers, memories, multiply-accumulate, divider and result register.
`default_nettype none
module acp_datapath #(
    parameter int MAX_CELLS  = acp_pkg::MAX_CELLS_DEF,
    parameter int MAX_VALUES = acp_pkg::MAX_VALUES_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire acp_pkg::t_cmd i_cmd,
    output acp_pkg::t_stat     o_stat,
    input  wire logic [2:0]    i_opcode,
    input  wire logic [9:0]    i_cell_req,
    input  wire logic [4:0]    i_choice,
    input  wire logic          i_cell_fixed,
    input  wire logic [10:0]   i_filled_count,
    input  wire logic          i_cfg_valid,
    input  wire logic [1:0]    i_cfg_index,
    input  wire logic [31:0]   i_cfg_data,
    input  wire logic          i_out_ready,
    output logic               o_out_valid,
    output logic [31:0]        o_level,
    output logic [31:0]        o_deposit,
    output logic               o_improved,
    output logic               o_solved,
    output logic               o_range_error
);
    localparam int TBL_DEPTH = MAX_CELLS * MAX_VALUES;
    localparam int TAW = $clog2(TBL_DEPTH);
    localparam int CAW = $clog2(MAX_CELLS);
    localparam int NW  = ($clog2(MAX_CELLS + 1) > 11) ? $clog2(MAX_CELLS + 1) : 11;
    localparam int DW  = NW + 16;
    localparam int DCW = $clog2(DW + 1);
    localparam int AW  = acp_pkg::ACC_W;

    logic [2:0]  r_op;
    logic [9:0]  r_cell;
    logic [4:0]  r_choice;
    logic        r_fixed;
    logic [10:0] r_filled;

    logic [10:0] r_cell_count;
    logic [31:0] r_init_level;
    logic [15:0] r_reinf_rate;
    logic [15:0] r_best_decay;

    logic [31:0]    r_fill_level;
    logic [31:0]    r_best_level;
    logic [TAW-1:0] r_cnt;
    logic [5:0]     r_word;
    logic [AW-1:0]  r_acc;
    logic [NW:0]    r_rem;
    logic [DW-1:0]  r_quot;
    logic [DCW-1:0] r_dcnt;

    logic [31:0] r_level;
    logic [31:0] r_deposit;
    logic        r_improved;
    logic        r_solved;
    logic        r_err;

    logic        r_out_valid;
    logic [31:0] r_out_level;
    logic [31:0] r_out_deposit;
    logic        r_out_improved;
    logic        r_out_solved;
    logic        r_out_err;

    logic [NW-1:0]  n_live;
    logic [NW-1:0]  filled_ext;
    logic [NW-1:0]  diff;
    logic           cell_err;
    logic           fill_err;
    logic           range_err;
    logic [TAW-1:0] item_idx;
    logic [TAW-1:0] rf_rd_idx;
    logic [TAW-1:0] rf_wr_idx;
    logic [5:0]     best_rd;
    logic [5:0]     cand_rd;
    logic [5:0]     src_word;
    logic           rf_hit;
    logic [31:0]    tbl_rd;
    logic [16:0]    keep;
    logic [16:0]    decay_keep;
    logic [31:0]    mul_a;
    logic [16:0]    mul_b;
    logic [48:0]    prod;
    logic [AW-1:0]  rsum;
    logic [31:0]    rounded;
    logic [NW:0]    rem_sh;
    logic           rem_ge;
    logic           tbl_we;
    logic [TAW-1:0] tbl_waddr;
    logic [31:0]    tbl_wdata;
    logic           best_we;
    logic [5:0]     best_wdata;

    assign n_live = (NW'(r_cell_count) > NW'(MAX_CELLS)) ? NW'(MAX_CELLS)
                                                          : NW'(r_cell_count);
    assign filled_ext = NW'(r_filled);
    assign diff       = n_live - filled_ext;
    assign cell_err   = (NW'(r_cell) >= n_live) || ({2'b00, r_choice} >= 7'(MAX_VALUES));
    assign fill_err   = filled_ext > n_live;

    always_comb begin
        case (r_op)
            acp_pkg::OP_READ, acp_pkg::OP_UPDATE, acp_pkg::OP_LOAD: range_err = cell_err;
            acp_pkg::OP_END: range_err = fill_err;
            default:         range_err = 1'b0;
        endcase
    end

    assign item_idx  = TAW'(r_cell) * TAW'(MAX_VALUES) + TAW'(r_choice);
    assign src_word  = r_improved ? cand_rd : best_rd;
    assign rf_rd_idx = TAW'(r_cnt[CAW-1:0]) * TAW'(MAX_VALUES) + TAW'(src_word[4:0]);
    assign rf_wr_idx = TAW'(r_cnt[CAW-1:0]) * TAW'(MAX_VALUES) + TAW'(r_word[4:0]);
    assign rf_hit    = src_word[5] && ({2'b00, src_word[4:0]} < 7'(MAX_VALUES))
                       && (NW'(r_cnt[CAW-1:0]) < n_live);

    assign keep       = 17'(32'd65536 - 32'(r_reinf_rate));
    assign decay_keep = 17'(32'd65536 - 32'(r_best_decay));

    always_comb begin
        case (i_cmd.mac_src)
            acp_pkg::MS_UPD_OLD: begin
                mul_a = tbl_rd;
                mul_b = acp_pkg::W_KEEP;
            end
            acp_pkg::MS_UPD_INIT: begin
                mul_a = r_init_level;
                mul_b = acp_pkg::W_ADD;
            end
            acp_pkg::MS_RF_OLD: begin
                mul_a = tbl_rd;
                mul_b = keep;
            end
            acp_pkg::MS_RF_BEST: begin
                mul_a = r_best_level;
                mul_b = {1'b0, r_reinf_rate};
            end
            acp_pkg::MS_DECAY: begin
                mul_a = r_best_level;
                mul_b = decay_keep;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod    = mul_a * mul_b;
    assign rsum    = r_acc + AW'(32768);
    assign rounded = (|rsum[AW-1:48]) ? 32'hFFFF_FFFF : rsum[47:16];

    assign rem_sh = {r_rem[NW-1:0], r_quot[DW-1]};
    assign rem_ge = rem_sh >= {1'b0, diff};

    assign tbl_we = i_cmd.tbl_we;
    always_comb begin
        case (i_cmd.tbl_wsel)
            acp_pkg::TW_SWEEP: begin
                tbl_waddr = r_cnt;
                tbl_wdata = r_fill_level;
            end
            acp_pkg::TW_ITEM: begin
                tbl_waddr = item_idx;
                tbl_wdata = rounded;
            end
            acp_pkg::TW_RF: begin
                tbl_waddr = rf_wr_idx;
                tbl_wdata = rounded;
            end
            default: begin
                tbl_waddr = r_cnt;
                tbl_wdata = r_fill_level;
            end
        endcase
    end

    assign best_we    = (i_cmd.best_sweep_we && (r_cnt < TAW'(MAX_CELLS)))
                        || (i_cmd.best_copy_we && r_improved);
    assign best_wdata = i_cmd.best_copy_we ? cand_rd : 6'd0;

    acp_ram #(.WIDTH(32), .DEPTH(TBL_DEPTH)) u_table (
        .i_clk  (i_clk),
        .i_we   (tbl_we),
        .i_waddr(tbl_waddr),
        .i_wdata(tbl_wdata),
        .i_re   (i_cmd.tbl_re),
        .i_raddr(i_cmd.tbl_rsel_rf ? rf_rd_idx : item_idx),
        .o_rdata(tbl_rd)
    );

    acp_ram #(.WIDTH(6), .DEPTH(MAX_CELLS)) u_best (
        .i_clk  (i_clk),
        .i_we   (best_we),
        .i_waddr(r_cnt[CAW-1:0]),
        .i_wdata(best_wdata),
        .i_re   (i_cmd.sol_re),
        .i_raddr(r_cnt[CAW-1:0]),
        .o_rdata(best_rd)
    );

    acp_ram #(.WIDTH(6), .DEPTH(MAX_CELLS)) u_cand (
        .i_clk  (i_clk),
        .i_we   (i_cmd.cand_we),
        .i_waddr(CAW'(r_cell)),
        .i_wdata({r_fixed, r_choice}),
        .i_re   (i_cmd.sol_re),
        .i_raddr(r_cnt[CAW-1:0]),
        .o_rdata(cand_rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell_count <= acp_pkg::RST_CELL_COUNT;
            r_init_level <= acp_pkg::RST_INIT_LEVEL;
            r_reinf_rate <= acp_pkg::RST_REINF_RATE;
            r_best_decay <= acp_pkg::RST_BEST_DECAY;
            r_fill_level <= acp_pkg::RST_INIT_LEVEL;
            r_best_level <= '0;
            r_cnt        <= '0;
            r_improved   <= 1'b0;
            r_solved     <= 1'b0;
            r_err        <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    acp_pkg::REG_CELL_COUNT: r_cell_count <= i_cfg_data[10:0];
                    acp_pkg::REG_INIT_LEVEL: r_init_level <= i_cfg_data;
                    acp_pkg::REG_REINF_RATE: r_reinf_rate <= i_cfg_data[15:0];
                    acp_pkg::REG_BEST_DECAY: r_best_decay <= i_cfg_data[15:0];
                    default: ;
                endcase
            end
            if (i_cmd.fill_latch) begin
                r_fill_level <= r_init_level;
            end
            if (i_cmd.cnt_clr) begin
                r_cnt <= '0;
            end else if (i_cmd.cnt_inc) begin
                r_cnt <= r_cnt + 1'b1;
            end
            if (i_cmd.best_clr) begin
                r_best_level <= '0;
            end else if (i_cmd.decay_wr) begin
                r_best_level <= rounded;
            end else if (i_cmd.commit && (r_deposit > r_best_level)) begin
                r_best_level <= r_deposit;
            end
            if (i_cmd.cap) begin
                r_improved <= 1'b0;
                r_solved   <= 1'b0;
                r_err      <= 1'b0;
            end else begin
                if (i_cmd.err_set) begin
                    r_err <= 1'b1;
                end
                if (i_cmd.commit && (r_deposit > r_best_level)) begin
                    r_improved <= 1'b1;
                    r_solved   <= (diff == '0);
                end
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            r_op      <= i_opcode;
            r_cell    <= i_cell_req;
            r_choice  <= i_choice;
            r_fixed   <= i_cell_fixed;
            r_filled  <= i_filled_count;
            r_level   <= '0;
            r_deposit <= '0;
        end else begin
            if (i_cmd.level_from_rd) begin
                r_level <= tbl_rd;
            end else if (i_cmd.level_from_mac) begin
                r_level <= rounded;
            end
            if (i_cmd.div_finish) begin
                r_deposit <= (diff == '0) ? 32'hFFFF_FFFF : 32'(r_quot);
            end
        end
        if (i_cmd.word_latch) begin
            r_word <= src_word;
        end
        case (i_cmd.mac_op)
            acp_pkg::MAC_LOAD: r_acc <= AW'(prod);
            acp_pkg::MAC_ADD:  r_acc <= r_acc + AW'(prod);
            default: ;
        endcase
        if (i_cmd.div_start) begin
            r_rem  <= '0;
            r_quot <= {n_live, 16'd0};
            r_dcnt <= '0;
        end else if (i_cmd.div_step) begin
            r_rem  <= rem_ge ? (rem_sh - {1'b0, diff}) : rem_sh;
            r_quot <= {r_quot[DW-2:0], rem_ge};
            r_dcnt <= r_dcnt + 1'b1;
        end
        if (i_cmd.out_load) begin
            r_out_level    <= r_level;
            r_out_deposit  <= r_deposit;
            r_out_improved <= r_improved;
            r_out_solved   <= r_solved;
            r_out_err      <= r_err;
        end
    end

    assign o_stat.op            = r_op;
    assign o_stat.range_err     = range_err;
    assign o_stat.diff_zero     = (diff == '0);
    assign o_stat.div_done      = (r_dcnt == DCW'(DW));
    assign o_stat.cnt_tbl_last  = (r_cnt == TAW'(TBL_DEPTH - 1));
    assign o_stat.cnt_cell_last = (r_cnt == TAW'(MAX_CELLS - 1));
    assign o_stat.rf_hit        = rf_hit;
    assign o_stat.out_free      = !r_out_valid || i_out_ready;

    assign o_out_valid   = r_out_valid;
    assign o_level       = r_out_level;
    assign o_deposit     = r_out_deposit;
    assign o_improved    = r_out_improved;
    assign o_solved      = r_out_solved;
    assign o_range_error = r_out_err;

    a_solved_needs_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_solved |-> r_improved)
        else $error("Solved flag set without a committed candidate.");

    a_error_is_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_err && !i_cmd.cap) |-> (!r_improved && r_level == '0 && r_deposit == '0))
        else $error("Rejected request produced result data.");

    a_commit_takes_deposit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.commit && !i_cmd.best_clr && r_deposit > r_best_level)
        |=> (r_best_level == $past(r_deposit)))
        else $error("Best level not updated on commit.");
endmodule
`default_nettype wire

@@ rtl/acp_ctrl.sv @@
// Controller state machine that sequences every operation over the datapath.
`default_nettype none
module acp_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_ready,
    input  wire acp_pkg::t_stat i_stat,
    output acp_pkg::t_cmd       o_cmd
);
    typedef enum logic [4:0] {
        S_INIT,
        S_IDLE,
        S_DISPATCH,
        S_CLEAR,
        S_RD_WAIT,
        S_UPD_ADD,
        S_UPD_WR,
        S_DIV,
        S_CMP,
        S_RF_RD,
        S_RF_CHK,
        S_RF_MUL,
        S_RF_ADD,
        S_RF_WR,
        S_DEC,
        S_DEC_WR,
        S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        case (r_state)
            S_INIT: begin
                o_cmd.tbl_we        = 1'b1;
                o_cmd.tbl_wsel      = acp_pkg::TW_SWEEP;
                o_cmd.best_sweep_we = 1'b1;
                if (i_stat.cnt_tbl_last) begin
                    o_cmd.cnt_clr = 1'b1;
                    n_state       = S_IDLE;
                end else begin
                    o_cmd.cnt_inc = 1'b1;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.cap = 1'b1;
                    n_state   = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                if (i_stat.range_err) begin
                    o_cmd.err_set = 1'b1;
                    n_state       = S_DONE;
                end else begin
                    case (i_stat.op)
                        acp_pkg::OP_CLEAR: begin
                            o_cmd.fill_latch = 1'b1;
                            o_cmd.best_clr   = 1'b1;
                            o_cmd.cnt_clr    = 1'b1;
                            n_state          = S_CLEAR;
                        end
                        acp_pkg::OP_READ, acp_pkg::OP_UPDATE: begin
                            o_cmd.tbl_re = 1'b1;
                            n_state      = S_RD_WAIT;
                        end
                        acp_pkg::OP_LOAD: begin
                            o_cmd.cand_we = 1'b1;
                            n_state       = S_DONE;
                        end
                        acp_pkg::OP_END: begin
                            if (i_stat.diff_zero) begin
                                o_cmd.div_finish = 1'b1;
                                n_state          = S_CMP;
                            end else begin
                                o_cmd.div_start = 1'b1;
                                n_state         = S_DIV;
                            end
                        end
                        default: n_state = S_DONE;
                    endcase
                end
            end
            S_CLEAR: begin
                o_cmd.tbl_we   = 1'b1;
                o_cmd.tbl_wsel = acp_pkg::TW_SWEEP;
                if (i_stat.cnt_tbl_last) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.cnt_inc = 1'b1;
                end
            end
            S_RD_WAIT: begin
                if (i_stat.op == acp_pkg::OP_READ) begin
                    o_cmd.level_from_rd = 1'b1;
                    n_state             = S_DONE;
                end else begin
                    o_cmd.mac_op  = acp_pkg::MAC_LOAD;
                    o_cmd.mac_src = acp_pkg::MS_UPD_OLD;
                    n_state       = S_UPD_ADD;
                end
            end
            S_UPD_ADD: begin
                o_cmd.mac_op  = acp_pkg::MAC_ADD;
                o_cmd.mac_src = acp_pkg::MS_UPD_INIT;
                n_state       = S_UPD_WR;
            end
            S_UPD_WR: begin
                o_cmd.tbl_we         = 1'b1;
                o_cmd.tbl_wsel       = acp_pkg::TW_ITEM;
                o_cmd.level_from_mac = 1'b1;
                n_state              = S_DONE;
            end
            S_DIV: begin
                if (i_stat.div_done) begin
                    o_cmd.div_finish = 1'b1;
                    n_state          = S_CMP;
                end else begin
                    o_cmd.div_step = 1'b1;
                end
            end
            S_CMP: begin
                o_cmd.commit  = 1'b1;
                o_cmd.cnt_clr = 1'b1;
                n_state       = S_RF_RD;
            end
            S_RF_RD: begin
                o_cmd.sol_re = 1'b1;
                n_state      = S_RF_CHK;
            end
            S_RF_CHK: begin
                o_cmd.word_latch   = 1'b1;
                o_cmd.best_copy_we = 1'b1;
                if (i_stat.rf_hit) begin
                    o_cmd.tbl_re      = 1'b1;
                    o_cmd.tbl_rsel_rf = 1'b1;
                    n_state           = S_RF_MUL;
                end else if (i_stat.cnt_cell_last) begin
                    n_state = S_DEC;
                end else begin
                    o_cmd.cnt_inc = 1'b1;
                    n_state       = S_RF_RD;
                end
            end
            S_RF_MUL: begin
                o_cmd.mac_op  = acp_pkg::MAC_LOAD;
                o_cmd.mac_src = acp_pkg::MS_RF_OLD;
                n_state       = S_RF_ADD;
            end
            S_RF_ADD: begin
                o_cmd.mac_op  = acp_pkg::MAC_ADD;
                o_cmd.mac_src = acp_pkg::MS_RF_BEST;
                n_state       = S_RF_WR;
            end
            S_RF_WR: begin
                o_cmd.tbl_we   = 1'b1;
                o_cmd.tbl_wsel = acp_pkg::TW_RF;
                if (i_stat.cnt_cell_last) begin
                    n_state = S_DEC;
                end else begin
                    o_cmd.cnt_inc = 1'b1;
                    n_state       = S_RF_RD;
                end
            end
            S_DEC: begin
                o_cmd.mac_op  = acp_pkg::MAC_LOAD;
                o_cmd.mac_src = acp_pkg::MS_DECAY;
                n_state       = S_DEC_WR;
            end
            S_DEC_WR: begin
                o_cmd.decay_wr = 1'b1;
                n_state        = S_DONE;
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);
endmodule
`default_nettype wire

@@ rtl/ant_colony_pheromone_engine.sv @@
// Top level of the pheromone engine: controller, datapath and channel wiring.
//
//  Channel  Dir  Handshake        Payload
//  i_req    in   valid / ready    opcode, cell_req, choice, cell_fixed, filled_count
//  o_rsp    out  valid / ready    level, deposit, improved, solved, range_error
//  i_cfg    in   valid / ready=1  index, data
//
// Read and update wait on the registered table read; update uses the shared 32x17
// multiplier twice per entry. Clear sweeps every entry of the table.
// End iteration runs the bit-serial divider, then visits each cell in turn.
// After reset the table and best solution are swept.
// One request is in flight at a time; a waiting result stalls only the final stage.
`default_nettype none
module ant_colony_pheromone_engine #(
    parameter int MAX_CELLS  = acp_pkg::MAX_CELLS_DEF,
    parameter int MAX_VALUES = acp_pkg::MAX_VALUES_DEF
) (
    input wire logic  i_clk,
    input wire logic  i_rst_n,
    acp_req_if.sink   i_req,
    acp_rsp_if.source o_rsp,
    acp_cfg_if.sink   i_cfg
);
    acp_pkg::t_cmd  cmd;
    acp_pkg::t_stat stat;

    assign i_cfg.ready = 1'b1;

    acp_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_req.valid),
        .o_in_ready(i_req.ready),
        .i_stat    (stat),
        .o_cmd     (cmd)
    );

    acp_datapath #(
        .MAX_CELLS (MAX_CELLS),
        .MAX_VALUES(MAX_VALUES)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_opcode      (i_req.opcode),
        .i_cell_req    (i_req.cell_req),
        .i_choice      (i_req.choice),
        .i_cell_fixed  (i_req.cell_fixed),
        .i_filled_count(i_req.filled_count),
        .i_cfg_valid   (i_cfg.valid),
        .i_cfg_index   (i_cfg.index),
        .i_cfg_data    (i_cfg.data),
        .i_out_ready   (o_rsp.ready),
        .o_out_valid   (o_rsp.valid),
        .o_level       (o_rsp.level),
        .o_deposit     (o_rsp.deposit),
        .o_improved    (o_rsp.improved),
        .o_solved      (o_rsp.solved),
        .o_range_error (o_rsp.range_error)
    );
endmodule
`default_nettype wire

@@ bench/ant_colony_pheromone_engine_test.sv @@
// Self-checking testbench of the pheromone engine with a built-in predictor and random traffic.
`timescale 1ns / 1ps
module ant_colony_pheromone_engine_test;

    localparam int CELLS = acp_pkg::MAX_CELLS_DEF;
    localparam int VALUES = acp_pkg::MAX_VALUES_DEF;
    localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
    localparam logic [2:0] OP_SPARE_LAST = 3'd7;
    localparam int CYCLE_LIMIT = 20000000;
    localparam int LONG_HOLD = 400;

    typedef struct {
        logic [2:0]  op;
        logic [9:0]  cell_no;
        logic [4:0]  choice;
        logic        fixed;
        logic [10:0] filled;
    } t_request;

    typedef struct {
        logic [31:0] level;
        logic [31:0] deposit;
        logic        improved;
        logic        solved;
        logic        range_error;
    } t_outcome;

    logic i_clk;
    logic i_rst_n;

    acp_req_if req_ch();
    acp_rsp_if rsp_ch();
    acp_cfg_if cfg_ch();

    ant_colony_pheromone_engine dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_ch),
        .o_rsp  (rsp_ch),
        .i_cfg  (cfg_ch)
    );

    // Predictor state.
    logic [31:0] pher_tbl [0:CELLS*VALUES-1];
    logic [5:0]  best_sol [0:CELLS-1];
    logic [5:0]  cand_sol [0:CELLS-1];
    bit          cand_known [0:CELLS-1];
    bit          best_known [0:CELLS-1];
    logic [31:0] best_lvl;
    logic [10:0] cfg_cells;
    logic [31:0] cfg_tau0;
    logic [15:0] cfg_rho;
    logic [15:0] cfg_decay;

    t_request pending_requests[$];
    t_outcome expected_outcomes[$];

    int  mismatches;
    int  cycle_count;
    bit  req_fire;
    bit  quiet;
    bit  hold_request;
    int  send_gap;
    int  recv_gap;
    int  hold_left;

    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    function automatic logic [31:0] round_sat(logic [63:0] sum);
        logic [63:0] r;
        r = (sum + 64'd32768) >> 16;
        return (r > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : r[31:0];
    endfunction

    function automatic logic [10:0] live_count();
        return (cfg_cells > CELLS) ? 11'(CELLS) : cfg_cells;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 55) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic fill_table();
        for (int i = 0; i < CELLS*VALUES; i++) pher_tbl[i] = cfg_tau0;
    endtask

    function automatic logic [31:0] deposit_of(logic [10:0] n, logic [10:0] filled);
        logic [63:0] q;
        if (n == filled) return 32'hFFFF_FFFF;
        q = ({53'd0, n} << 16) / (n - filled);
        return q[31:0];
    endfunction

    task automatic apply_pheromone_step(input t_request rq, output t_outcome res);
        logic [10:0] n;
        logic [31:0] dep;
        int idx;
        n = live_count();
        res = '{default: '0};
        if (rq.op == acp_pkg::OP_CLEAR) begin
            fill_table();
            best_lvl = '0;
        end else if (rq.op == acp_pkg::OP_READ || rq.op == acp_pkg::OP_UPDATE
                     || rq.op == acp_pkg::OP_LOAD) begin
            if ({1'b0, rq.cell_no} >= n) begin
                res.range_error = 1'b1;
            end else if (rq.op == acp_pkg::OP_LOAD) begin
                cand_sol[rq.cell_no] = {rq.fixed, rq.choice};
                cand_known[rq.cell_no] = 1'b1;
            end else begin
                idx = rq.cell_no * VALUES + rq.choice;
                if (rq.op == acp_pkg::OP_UPDATE) begin
                    pher_tbl[idx] = round_sat(64'(pher_tbl[idx]) * 64'(acp_pkg::W_KEEP)
                                              + 64'(cfg_tau0) * 64'(acp_pkg::W_ADD));
                end
                res.level = pher_tbl[idx];
            end
        end else if (rq.op == acp_pkg::OP_END) begin
            if (rq.filled > n) begin
                res.range_error = 1'b1;
            end else begin
                dep = deposit_of(n, rq.filled);
                res.deposit = dep;
                if (dep > best_lvl) begin
                    res.improved = 1'b1;
                    res.solved = (rq.filled == n);
                    for (int i = 0; i < CELLS; i++) begin
                        best_sol[i] = cand_sol[i];
                        best_known[i] = cand_known[i];
                    end
                    best_lvl = dep;
                end
                for (int i = 0; i < n; i++) begin
                    if (best_sol[i][5]) begin
                        idx = i * VALUES + best_sol[i][4:0];
                        pher_tbl[idx] = round_sat(64'(pher_tbl[idx]) * 64'(17'd65536 - cfg_rho)
                                                  + 64'(best_lvl) * 64'(cfg_rho));
                    end
                end
                best_lvl = round_sat(64'(best_lvl) * 64'(17'd65536 - cfg_decay));
            end
        end
    endtask

    // An end of iteration must never reach candidate or best cells that were never loaded;
    // such a request is turned into a load of a missing cell, or into a clear.
    task automatic issue(input t_request rq);
        t_request fix;
        t_outcome res;
        logic [10:0] n;
        bit commits;
        int missing;
        bit stale;
        fix = rq;
        n = live_count();
        if (rq.op == acp_pkg::OP_END && rq.filled <= n) begin
            commits = deposit_of(n, rq.filled) > best_lvl;
            missing = -1;
            stale = 1'b0;
            for (int i = 0; i < n; i++) begin
                if (!cand_known[i] && missing < 0) missing = i;
                if (!best_known[i]) stale = 1'b1;
            end
            if ((commits || stale) && missing >= 0) begin
                fix.op = acp_pkg::OP_LOAD;
                fix.cell_no = 10'(missing);
                fix.choice = 5'($urandom_range(0, 31));
                fix.fixed = $urandom_range(0, 3) != 0;
            end else if (stale && !commits) begin
                fix.op = acp_pkg::OP_CLEAR;
            end
        end
        apply_pheromone_step(fix, res);
        pending_requests.push_back(fix);
        expected_outcomes.push_back(res);
    endtask

    task automatic wait_idle();
        while (pending_requests.size() != 0 || expected_outcomes.size() != 0 || req_ch.valid)
            @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic write_reg(input acp_pkg::t_reg_idx idx, input logic [31:0] val);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= val;
        do @(posedge i_clk); while (!cfg_ch.ready);
        case (idx)
            acp_pkg::REG_CELL_COUNT: cfg_cells = val[10:0];
            acp_pkg::REG_INIT_LEVEL: cfg_tau0 = val;
            acp_pkg::REG_REINF_RATE: cfg_rho = val[15:0];
            default: cfg_decay = val[15:0];
        endcase
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    function automatic t_request random_request();
        t_request rq;
        logic [10:0] n;
        int r;
        n = live_count();
        r = $urandom_range(0, 999);
        rq.op = (r < 5) ? acp_pkg::OP_CLEAR : (r < 220) ? acp_pkg::OP_READ :
                (r < 450) ? acp_pkg::OP_UPDATE : (r < 750) ? acp_pkg::OP_LOAD :
                (r < 970) ? acp_pkg::OP_END :
                3'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
        if (n == 0 || $urandom_range(0, 9) == 0) rq.cell_no = 10'($urandom_range(0, 1023));
        else rq.cell_no = 10'($urandom_range(0, n - 1));
        rq.choice = 5'($urandom_range(0, 31));
        rq.fixed = $urandom_range(0, 3) != 0;
        r = $urandom_range(0, 9);
        if (r == 0) rq.filled = 11'($urandom_range(0, 2047));
        else if (r < 5) rq.filled = n - 11'($urandom_range(0, (n < 3) ? n : 3));
        else rq.filled = 11'($urandom_range(0, n));
        return rq;
    endfunction

    task automatic run_phase(input logic [10:0] cells, input logic [31:0] tau0,
                             input logic [15:0] rho, input logic [15:0] decay,
                             input int count, input bit with_hold);
        wait_idle();
        write_reg(acp_pkg::REG_CELL_COUNT, {21'd0, cells});
        write_reg(acp_pkg::REG_INIT_LEVEL, tau0);
        write_reg(acp_pkg::REG_REINF_RATE, {16'd0, rho});
        write_reg(acp_pkg::REG_BEST_DECAY, {16'd0, decay});
        quiet = !quiet;
        if (with_hold) hold_request = 1'b1;
        for (int k = 0; k < count; k++) issue(random_request());
    endtask

    task automatic directed(input logic [2:0] op, input int cell_no, input int choice,
                            input bit fixed, input int filled);
        t_request rq;
        rq.op = op;
        rq.cell_no = 10'(cell_no);
        rq.choice = 5'(choice);
        rq.fixed = fixed;
        rq.filled = 11'(filled);
        issue(rq);
    endtask

    initial begin
        i_rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.opcode = '0;
        req_ch.cell_req = '0;
        req_ch.choice = '0;
        req_ch.cell_fixed = 1'b0;
        req_ch.filled_count = '0;
        rsp_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = '0;
        cfg_ch.data = '0;
        mismatches = 0;
        quiet = 1'b0;
        hold_request = 1'b0;
        cfg_cells = acp_pkg::RST_CELL_COUNT;
        cfg_tau0 = acp_pkg::RST_INIT_LEVEL;
        cfg_rho = acp_pkg::RST_REINF_RATE;
        cfg_decay = acp_pkg::RST_BEST_DECAY;
        best_lvl = '0;
        fill_table();
        for (int i = 0; i < CELLS; i++) begin
            best_sol[i] = '0;
            cand_sol[i] = '0;
            best_known[i] = 1'b1;
            cand_known[i] = 1'b0;
        end
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        directed(acp_pkg::OP_READ, 0, 0, 0, 0);
        directed(acp_pkg::OP_READ, 80, 31, 0, 0);
        directed(acp_pkg::OP_READ, 81, 0, 0, 0);
        directed(acp_pkg::OP_UPDATE, 0, 0, 0, 0);
        directed(acp_pkg::OP_UPDATE, 80, 31, 1, 0);
        directed(acp_pkg::OP_UPDATE, 1023, 31, 1, 2047);
        directed(acp_pkg::OP_LOAD, 1023, 7, 1, 0);
        for (int i = 0; i < 81; i++) directed(acp_pkg::OP_LOAD, i, i % 32, i % 3 != 0, 0);
        directed(acp_pkg::OP_END, 0, 0, 0, 0);
        directed(acp_pkg::OP_END, 0, 0, 0, 80);
        directed(acp_pkg::OP_END, 0, 0, 0, 81);
        directed(acp_pkg::OP_END, 0, 0, 0, 82);
        directed(acp_pkg::OP_END, 0, 0, 0, 2047);
        directed(acp_pkg::OP_READ, 5, 5, 0, 0);
        directed(OP_SPARE_FIRST, 1023, 31, 1, 2047);
        directed(OP_SPARE_LAST, 0, 0, 0, 0);
        directed(acp_pkg::OP_CLEAR, 0, 0, 0, 0);
        directed(acp_pkg::OP_READ, 6, 6, 0, 0);

        run_phase(11'd1, 32'd0, 16'd0, 16'd0, 100, 1'b0);
        run_phase(11'd16, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 200, 1'b0);
        run_phase(11'd1024, acp_pkg::RST_INIT_LEVEL, acp_pkg::RST_REINF_RATE,
                  acp_pkg::RST_BEST_DECAY, 200, 1'b0);
        run_phase(11'd2047, $urandom, 16'($urandom), 16'($urandom), 80, 1'b0);
        run_phase(11'd0, $urandom, 16'($urandom), 16'($urandom), 40, 1'b0);
        run_phase(11'd40, $urandom, 16'($urandom), 16'($urandom), 300, 1'b1);
        run_phase(11'd5, $urandom_range(0, 65535), 16'($urandom), 16'($urandom), 300, 1'b0);
        run_phase(11'd64, $urandom, 16'hFFFF, 16'd0, 250, 1'b0);
        run_phase(acp_pkg::RST_CELL_COUNT, acp_pkg::RST_INIT_LEVEL, acp_pkg::RST_REINF_RATE,
                  acp_pkg::RST_BEST_DECAY, 80, 1'b0);

        while (pending_requests.size() != 0 || expected_outcomes.size() != 0)
            @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (mismatches == 0 && expected_outcomes.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    always @(posedge i_clk) begin
        req_fire <= req_ch.valid && req_ch.ready;
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial cycle_count = 0;
    initial send_gap = 0;
    initial recv_gap = 0;
    initial hold_left = 0;

    // Request driver.
    always @(negedge i_clk) begin
        t_request rq;
        bit offer;
        offer = req_ch.valid && !req_fire;
        if (i_rst_n && !offer) begin
            if (send_gap > 0) begin
                send_gap <= send_gap - 1;
            end else if (pending_requests.size() != 0) begin
                rq = pending_requests.pop_front();
                req_ch.opcode <= rq.op;
                req_ch.cell_req <= rq.cell_no;
                req_ch.choice <= rq.choice;
                req_ch.cell_fixed <= rq.fixed;
                req_ch.filled_count <= rq.filled;
                send_gap <= pick_gap();
                offer = 1'b1;
            end
        end
        req_ch.valid <= offer;
    end

    // Result receiver with a one-time long hold-off.
    always @(negedge i_clk) begin
        bit take;
        take = 1'b0;
        if (hold_request && hold_left == 0) begin
            hold_left <= LONG_HOLD;
            hold_request <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end else if (recv_gap > 0) begin
            recv_gap <= recv_gap - 1;
        end else begin
            take = i_rst_n;
            recv_gap <= pick_gap();
        end
        rsp_ch.ready <= take;
    end

    always @(posedge i_clk) begin
        t_outcome want;
        if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_outcomes.size() == 0) begin
                mismatches <= mismatches + 1;
                if (mismatches < 10) $display("unexpected result at cycle %0d", cycle_count);
            end else begin
                want = expected_outcomes.pop_front();
                if (rsp_ch.level !== want.level || rsp_ch.deposit !== want.deposit
                        || rsp_ch.improved !== want.improved || rsp_ch.solved !== want.solved
                        || rsp_ch.range_error !== want.range_error) begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10) begin
                        $display("mismatch at cycle %0d: expected lvl=%h dep=%h imp=%b sol=%b err=%b",
                                 cycle_count, want.level, want.deposit, want.improved,
                                 want.solved, want.range_error);
                        $display("  actual lvl=%h dep=%h imp=%b sol=%b err=%b",
                                 rsp_ch.level, rsp_ch.deposit, rsp_ch.improved,
                                 rsp_ch.solved, rsp_ch.range_error);
                    end
                end
            end
        end
    end

endmodule

@@ filelist.f @@
rtl/acp_pkg.sv
rtl/acp_if.sv
rtl/acp_ram.sv
rtl/acp_datapath.sv
rtl/acp_ctrl.sv
rtl/ant_colony_pheromone_engine.sv
bench/ant_colony_pheromone_engine_test.sv
